### hw/rtl/lcwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcwm_pkg
// Shared types and constants of the load class weighted moments core.
// ----------------------------------------------------------------------------
package lcwm_pkg;

	localparam int VW     = 48;  // Q24.24 result width
	localparam int CELLW  = 26;  // grid cell width
	localparam int WGTW   = 25;  // input weight width
	localparam int CNTW   = 6;   // input count width
	localparam int FRAC   = 24;
	localparam int QDEPTH = 4;
	localparam int QPW    = 2;

	localparam logic [VW-1:0]    VAL_MAX  = '1;
	localparam logic [CELLW-1:0] CELL_MAX = '1;

	localparam logic [2:0] ST_MEAN_HET = 3'd0;
	localparam logic [2:0] ST_VAR_HET  = 3'd1;
	localparam logic [2:0] ST_MEAN_HOM = 3'd2;
	localparam logic [2:0] ST_VAR_HOM  = 3'd3;
	localparam logic [2:0] ST_MEAN_TOT = 3'd4;
	localparam logic [2:0] ST_VAR_TOT  = 3'd5;
	localparam logic [2:0] ST_RATIO    = 3'd6;

	// back end status seen by the front end
	typedef struct packed {
		logic clearing;
	} lcwm_bstat_t;

endpackage
`default_nettype wire

### hw/rtl/lcwm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcwm_front
// Accepts class requests, checks them against the grid and forms the cell
// index; pushes the classified request into the queue.
// ----------------------------------------------------------------------------
module lcwm_front import lcwm_pkg::*; #(
	parameter int MAX_HET = 63,
	parameter int MAX_HOM = 63,
	localparam int CELLS = (MAX_HET + 1) * (MAX_HOM + 1),
	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1,
	localparam int QW = AW + 2 + WGTW
) (
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [CNTW-1:0] het_count,
	input  wire logic [CNTW-1:0] hom_count,
	input  wire logic [WGTW-1:0] weight,
	input  wire logic            last,
	input  wire lcwm_bstat_t     bstat,
	input  wire logic            q_full,
	output logic                 push,
	output logic [QW-1:0]        push_data
);

	logic          in_range;
	logic [15:0]   idx_wide;
	logic [AW-1:0] idx;

	assign in_range = ({2'b00, het_count} <= 8'(MAX_HET)) &&
		({2'b00, hom_count} <= 8'(MAX_HOM));
	assign idx_wide = 16'(het_count) * 16'(MAX_HOM + 1) + 16'(hom_count);
	assign idx      = AW'(idx_wide);

	// hold off while the grid is being swept clear
	assign in_ready  = !q_full && !bstat.clearing;
	assign push      = in_valid && in_ready;
	assign push_data = {idx, in_range, last, weight};

endmodule
`default_nettype wire

### hw/rtl/lcwm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcwm_queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module lcwm_queue import lcwm_pkg::*; #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic              head_valid,
	output logic [W-1:0]      head_data
);

	logic [W-1:0]   mem_q [QDEPTH];
	logic [QPW-1:0] wp_q, rp_q;
	logic [QPW:0]   cnt_q;

	assign full       = (cnt_q == (QPW+1)'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_data;
	end

endmodule
`default_nettype wire

### hw/rtl/lcwm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcwm_back
// Grid store, weight accumulation, mean and variance passes, ratio divider
// and result sequencing.
// ----------------------------------------------------------------------------
module lcwm_back import lcwm_pkg::*; #(
	parameter int MAX_HET = 63,
	parameter int MAX_HOM = 63,
	localparam int CELLS = (MAX_HET + 1) * (MAX_HOM + 1),
	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1,
	localparam int QW = AW + 2 + WGTW,
	localparam int HW = (MAX_HET > 0) ? $clog2(MAX_HET + 1) : 1,
	localparam int OW = (MAX_HOM > 0) ? $clog2(MAX_HOM + 1) : 1,
	localparam int TW = $clog2(MAX_HET + 2 * MAX_HOM + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire logic [QW-1:0] q_data,
	output logic               q_pop,
	output lcwm_bstat_t        bstat,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [2:0]         stat_code,
	output logic [VW-1:0]      value,
	output logic               saturated,
	output logic               last_result
);

	localparam int MPW = TW + CELLW;
	localparam int DWW = 75;
	localparam int PW  = 124;

	localparam logic [3:0] S_CLR      = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_UPD      = 4'd2;
	localparam logic [3:0] S_M_RD     = 4'd3;
	localparam logic [3:0] S_M_MUL    = 4'd4;
	localparam logic [3:0] S_M_ACC    = 4'd5;
	localparam logic [3:0] S_V_RD     = 4'd6;
	localparam logic [3:0] S_V_LD     = 4'd7;
	localparam logic [3:0] S_V_D      = 4'd8;
	localparam logic [3:0] S_V_MUL    = 4'd9;
	localparam logic [3:0] S_DIV_INIT = 4'd10;
	localparam logic [3:0] S_DIV      = 4'd11;
	localparam logic [3:0] S_EMIT     = 4'd12;

	// multiply sequence steps for one variance term
	localparam logic [3:0] MS_LO      = 4'd0;
	localparam logic [3:0] MS_HI      = 4'd1;
	localparam logic [3:0] MS_P_FIRST = 4'd3;
	localparam logic [3:0] MS_P_LAST  = 4'd8;
	localparam logic [3:0] MS_DONE    = 4'd10;

	localparam logic [6:0] DIV_LAST = 7'd71;

	logic [3:0]       state_q;
	logic [AW-1:0]    addr_q;
	logic [HW-1:0]    het_i_q;
	logic [OW-1:0]    hom_i_q;
	logic             ovf_q;
	logic             out_valid_q;
	logic [2:0]       code_q;
	logic [3:0]       st_q;
	logic [1:0]       k_q;
	logic [6:0]       dcnt_q;
	logic             pv_s1;

	logic [CELLW-1:0] mem [CELLS];
	logic [CELLW-1:0] mem_rd_q;
	logic             mem_we;
	logic [AW-1:0]    mem_wa, mem_ra;
	logic [CELLW-1:0] mem_wd;

	logic [WGTW-1:0]  w_q;
	logic             lst_q;
	logic [AW-1:0]    q_idx_q;
	logic [VW-1:0]    mean_q [3];
	logic [VW-1:0]    var_q [3];
	logic             msat_q [3];
	logic             vsat_q [3];
	logic [MPW-1:0]   mp_q [3];
	logic [CELLW-1:0] cw_q;
	logic [VW-1:0]    d_q;
	logic [DWW-1:0]   dw_q;
	logic [PW-1:0]    p_q;
	logic [49:0]      prod_s1;
	logic [6:0]       sh_s1;
	logic             tgt_p_s1;
	logic [VW-1:0]    ratio_q;
	logic             rsat_q;
	logic [VW-1:0]    rem_q;
	logic [71:0]      dq_q;

	logic [AW-1:0]    q_idx;
	logic             q_inr, q_last;
	logic [WGTW-1:0]  q_w;
	logic [CELLW:0]   upd_sum;
	logic             upd_clip;
	logic             start_mean, last_cell;
	logic [TW-1:0]    cnt [3];
	logic [TW-1:0]    cnt_k;
	logic [VW-1:0]    tq, mean_k;
	logic             iss_v, iss_p;
	logic [25:0]      mul_a;
	logic [23:0]      mul_b;
	logic [6:0]       iss_sh;
	logic [3:0]       ik;
	logic             tsat;
	logic [VW-1:0]    term;
	logic [VW:0]      vsum;
	logic [VW:0]      r2;
	logic             dge;
	logic             ratio_big;

	assign q_idx  = q_data[QW-1 -: AW];
	assign q_inr  = q_data[WGTW+1];
	assign q_last = q_data[WGTW];
	assign q_w    = q_data[WGTW-1:0];

	assign q_pop          = (state_q == S_IDLE) && q_valid;
	assign bstat.clearing = (state_q == S_CLR);

	assign upd_sum  = {1'b0, mem_rd_q} + (CELLW+1)'(w_q);
	assign upd_clip = upd_sum[CELLW];

	assign start_mean = ((state_q == S_IDLE) && q_valid && !q_inr && q_last) ||
		((state_q == S_UPD) && lst_q);
	assign last_cell = (addr_q == AW'(CELLS - 1));

	assign cnt[0] = TW'(het_i_q);
	assign cnt[1] = TW'(hom_i_q);
	assign cnt[2] = TW'(het_i_q) + (TW'(hom_i_q) << 1);

	always_comb begin
		case (k_q)
			2'd0:    cnt_k = cnt[0];
			2'd1:    cnt_k = cnt[1];
			default: cnt_k = cnt[2];
		endcase
		mean_k = mean_q[k_q];
		tq     = VW'(cnt_k) << FRAC;
	end

	// grid memory
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = '0;
		mem_ra = addr_q;
		if (state_q == S_CLR)
			mem_we = 1'b1;
		if (state_q == S_IDLE)
			mem_ra = q_idx;
		if (state_q == S_UPD) begin
			mem_we = 1'b1;
			mem_wa = q_idx_q;
			mem_wd = upd_clip ? CELL_MAX : upd_sum[CELLW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[mem_ra];
	end

	// d*d*w over partial products: d*w first, then (d*w)*d
	always_comb begin
		iss_v  = 1'b0;
		iss_p  = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		iss_sh = '0;
		ik     = st_q - MS_P_FIRST;
		if (state_q == S_V_MUL) begin
			if (st_q == MS_LO) begin
				iss_v = 1'b1;
				mul_a = cw_q;
				mul_b = d_q[23:0];
			end else if (st_q == MS_HI) begin
				iss_v  = 1'b1;
				mul_a  = cw_q;
				mul_b  = d_q[47:24];
				iss_sh = 7'd24;
			end else if (st_q inside {[MS_P_FIRST:MS_P_LAST]}) begin
				iss_v = 1'b1;
				iss_p = 1'b1;
				case (ik[2:1])
					2'd0:    mul_a = {1'b0, dw_q[24:0]};
					2'd1:    mul_a = {1'b0, dw_q[49:25]};
					default: mul_a = {1'b0, dw_q[74:50]};
				endcase
				mul_b  = ik[0] ? d_q[47:24] : d_q[23:0];
				iss_sh = 7'(25 * ik[2:1]) + (ik[0] ? 7'd24 : 7'd0);
			end
		end
	end

	assign tsat = |p_q[PW-1:96];
	assign term = tsat ? VAL_MAX : p_q[95:48];
	assign vsum = {1'b0, var_q[k_q]} + {1'b0, term};

	assign r2        = {rem_q, dq_q[71]};
	assign dge       = (r2 >= {1'b0, mean_q[2]});
	assign ratio_big = ({24'b0, var_q[2]} >= {mean_q[2], 24'b0});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			addr_q      <= '0;
			het_i_q     <= '0;
			hom_i_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			code_q      <= ST_MEAN_HET;
			st_q        <= '0;
			k_q         <= '0;
			dcnt_q      <= '0;
			pv_s1       <= 1'b0;
		end else begin
			pv_s1 <= iss_v;
			// the last request's cell can clip too
			if (state_q == S_UPD)
				ovf_q <= ovf_q | upd_clip;
			if (start_mean) begin
				state_q <= S_M_RD;
				addr_q  <= '0;
				het_i_q <= '0;
				hom_i_q <= '0;
			end else begin
				case (state_q)
					S_CLR: begin
						addr_q <= addr_q + 1'b1;
						if (last_cell) begin
							addr_q  <= '0;
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (q_valid && q_inr)
							state_q <= S_UPD;
					end
					S_UPD: begin
						state_q <= S_IDLE;
					end
					S_M_RD:  state_q <= S_M_MUL;
					S_M_MUL: state_q <= S_M_ACC;
					S_M_ACC, S_V_LD, S_V_MUL: begin
						if (state_q == S_V_MUL)
							st_q <= st_q + 1'b1;
						if (state_q == S_V_LD && mem_rd_q != '0) begin
							k_q     <= '0;
							state_q <= S_V_D;
						end else if (state_q == S_V_MUL && st_q != MS_DONE) begin
							state_q <= S_V_MUL;
						end else if (state_q == S_V_MUL && k_q != 2'd2) begin
							k_q     <= k_q + 1'b1;
							state_q <= S_V_D;
						end else if (last_cell) begin
							addr_q  <= '0;
							het_i_q <= '0;
							hom_i_q <= '0;
							state_q <= (state_q == S_M_ACC) ? S_V_RD : S_DIV_INIT;
						end else begin
							addr_q <= addr_q + 1'b1;
							if (hom_i_q == OW'(MAX_HOM)) begin
								hom_i_q <= '0;
								het_i_q <= het_i_q + 1'b1;
							end else begin
								hom_i_q <= hom_i_q + 1'b1;
							end
							state_q <= (state_q == S_M_ACC) ? S_M_RD : S_V_RD;
						end
					end
					S_V_RD: state_q <= S_V_LD;
					S_V_D: begin
						st_q    <= '0;
						state_q <= S_V_MUL;
					end
					S_DIV_INIT: begin
						dcnt_q <= '0;
						if (mean_q[2] == '0 || ratio_big) begin
							state_q     <= S_EMIT;
							out_valid_q <= 1'b1;
							code_q      <= ST_MEAN_HET;
						end else begin
							state_q <= S_DIV;
						end
					end
					S_DIV: begin
						dcnt_q <= dcnt_q + 1'b1;
						if (dcnt_q == DIV_LAST) begin
							state_q     <= S_EMIT;
							out_valid_q <= 1'b1;
							code_q      <= ST_MEAN_HET;
						end
					end
					S_EMIT: begin
						if (out_ready) begin
							if (code_q == ST_RATIO) begin
								out_valid_q <= 1'b0;
								ovf_q       <= 1'b0;
								addr_q      <= '0;
								state_q     <= S_CLR;
							end else begin
								code_q <= code_q + 1'b1;
							end
						end
					end
					default: state_q <= S_CLR;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (q_pop) begin
			w_q     <= q_w;
			lst_q   <= q_last;
			q_idx_q <= q_idx;
		end
		if (start_mean) begin
			for (int i = 0; i < 3; i++) begin
				mean_q[i] <= '0;
				msat_q[i] <= 1'b0;
				var_q[i]  <= '0;
				vsat_q[i] <= 1'b0;
			end
		end
		if (state_q == S_M_MUL) begin
			for (int i = 0; i < 3; i++)
				mp_q[i] <= MPW'(cnt[i]) * MPW'(mem_rd_q);
		end
		if (state_q == S_M_ACC) begin
			for (int i = 0; i < 3; i++) begin
				logic [VW:0] s;
				s = {1'b0, mean_q[i]} + (VW+1)'(mp_q[i]);
				if (s[VW]) begin
					mean_q[i] <= VAL_MAX;
					msat_q[i] <= 1'b1;
				end else begin
					mean_q[i] <= s[VW-1:0];
				end
			end
		end
		if (state_q == S_V_LD)
			cw_q <= mem_rd_q;
		if (state_q == S_V_D) begin
			d_q  <= (tq >= mean_k) ? tq - mean_k : mean_k - tq;
			dw_q <= '0;
			p_q  <= '0;
		end
		prod_s1  <= 50'(mul_a) * 50'(mul_b);
		sh_s1    <= iss_sh;
		tgt_p_s1 <= iss_p;
		if (pv_s1) begin
			if (tgt_p_s1)
				p_q <= p_q + (PW'(prod_s1) << sh_s1);
			else
				dw_q <= dw_q + (DWW'(prod_s1) << sh_s1);
		end
		if (state_q == S_V_MUL && st_q == MS_DONE) begin
			if (tsat || vsum[VW]) begin
				var_q[k_q]  <= VAL_MAX;
				vsat_q[k_q] <= 1'b1;
			end else begin
				var_q[k_q] <= vsum[VW-1:0];
			end
		end
		if (state_q == S_DIV_INIT) begin
			rsat_q <= msat_q[2] | vsat_q[2];
			rem_q  <= '0;
			dq_q   <= {var_q[2], 24'b0};
			if (mean_q[2] == '0) begin
				ratio_q <= '0;
			end else if (ratio_big) begin
				ratio_q <= VAL_MAX;
				rsat_q  <= 1'b1;
			end
		end
		if (state_q == S_DIV) begin
			rem_q <= dge ? VW'(r2 - {1'b0, mean_q[2]}) : VW'(r2);
			dq_q  <= {dq_q[70:0], dge};
			if (dcnt_q == DIV_LAST)
				ratio_q <= {dq_q[46:0], dge};
		end
	end

	// result select
	always_comb begin
		case (code_q)
			ST_MEAN_HET: begin value = mean_q[0]; saturated = msat_q[0]; end
			ST_VAR_HET:  begin value = var_q[0];  saturated = msat_q[0] | vsat_q[0]; end
			ST_MEAN_HOM: begin value = mean_q[1]; saturated = msat_q[1]; end
			ST_VAR_HOM:  begin value = var_q[1];  saturated = msat_q[1] | vsat_q[1]; end
			ST_MEAN_TOT: begin value = mean_q[2]; saturated = msat_q[2]; end
			ST_VAR_TOT:  begin value = var_q[2];  saturated = msat_q[2] | vsat_q[2]; end
			ST_RATIO:    begin value = ratio_q;   saturated = rsat_q; end
			default:     begin value = '0;        saturated = 1'b0; end
		endcase
		saturated = saturated | ovf_q;
	end

	assign out_valid   = out_valid_q;
	assign stat_code   = code_q;
	assign last_result = (code_q == ST_RATIO);

endmodule
`default_nettype wire

### hw/rtl/load_class_weighted_moments_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// load_class_weighted_moments_core
// Weighted mean and variance of mutation load over a grid of load classes.
// ----------------------------------------------------------------------------
// Each in-range request adds its weight into the grid cell of its class in the
// back end (read, then saturating write on the grid memory, which has one read
// and one write port), with a four-entry queue in front. On a request marked
// last the back end makes a mean pass (read, multiply, accumulate per cell), a
// variance pass (read and load per cell, then for a nonzero cell three terms
// on the shared 26x24 multiplier), runs the ratio divider, and then presents the
// seven results. After the seventh result is taken, and after reset, the
// grid's (MAX_HET+1)*(MAX_HOM+1) cells (4096 by default) are swept clear,
// during which in_ready is low.
// ----------------------------------------------------------------------------
module load_class_weighted_moments_core import lcwm_pkg::*; #(
	parameter int MAX_HET = 63,
	parameter int MAX_HOM = 63
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [CNTW-1:0] het_count,
	input  wire logic [CNTW-1:0] hom_count,
	input  wire logic [WGTW-1:0] weight,
	input  wire logic            last,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [2:0]           stat_code,
	output logic [VW-1:0]        value,
	output logic                 saturated,
	output logic                 last_result
);

	localparam int CELLS = (MAX_HET + 1) * (MAX_HOM + 1);
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int QW    = AW + 2 + WGTW;

	lcwm_bstat_t   bstat;
	logic          q_full, push, pop, head_valid;
	logic [QW-1:0] push_data, head_data;

	lcwm_front #(.MAX_HET(MAX_HET), .MAX_HOM(MAX_HOM)) u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.het_count (het_count),
		.hom_count (hom_count),
		.weight    (weight),
		.last      (last),
		.bstat     (bstat),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	lcwm_queue #(.W(QW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	lcwm_back #(.MAX_HET(MAX_HET), .MAX_HOM(MAX_HOM)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (head_valid),
		.q_data      (head_data),
		.q_pop       (pop),
		.bstat       (bstat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.stat_code   (stat_code),
		.value       (value),
		.saturated   (saturated),
		.last_result (last_result)
	);

endmodule
`default_nettype wire

### dv/lcwm_moments_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcwm_moments_checker
// Watches both channels of the moments core, accumulates its own class grid,
// works out the seven batch statistics on each last request and compares
// them in order against what the core emits.
// ----------------------------------------------------------------------------
module lcwm_moments_checker import lcwm_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            in_ready,
	input  wire logic [CNTW-1:0] het_count,
	input  wire logic [CNTW-1:0] hom_count,
	input  wire logic [WGTW-1:0] weight,
	input  wire logic            last,
	input  wire logic            out_valid,
	input  wire logic            out_ready,
	input  wire logic [2:0]      stat_code,
	input  wire logic [VW-1:0]   value,
	input  wire logic            saturated,
	input  wire logic            last_result,
	output int                   fail_count,
	output int                   pending,
	output int                   batches_done,
	output int                   stats_checked
);

	typedef struct {
		logic [2:0]    code;
		logic [VW-1:0] val;
		logic          sat;
		logic          fin;
	} stat_t;

	localparam logic [2:0] STAT_ORDER [7] = '{ST_MEAN_HET, ST_VAR_HET, ST_MEAN_HOM,
		ST_VAR_HOM, ST_MEAN_TOT, ST_VAR_TOT, ST_RATIO};

	logic [CELLW-1:0] class_wt [int];
	logic             cell_clipped;
	stat_t            expected_stats [$];

	initial begin
		fail_count = 0;
		pending = 0;
		batches_done = 0;
		stats_checked = 0;
		cell_clipped = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [VW-1:0] got,
			input logic [VW-1:0] want);
		$display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic logic [VW-1:0] clip48(input logic [127:0] x, inout logic sat);
		if (x > {80'd0, VAL_MAX}) begin
			sat = 1'b1;
			return VAL_MAX;
		end
		return x[VW-1:0];
	endfunction

	task automatic predict_batch_stats();
		logic [VW-1:0]  mean [3];
		logic [VW-1:0]  vsum [3];
		logic           msat [3];
		logic           vsat [3];
		logic [127:0]   acc, prod, tq, d, q;
		logic [7:0]     cnt [3];
		logic           rsat;
		logic [VW-1:0]  ratio;
		stat_t          s;
		for (int k = 0; k < 3; k++) begin
			msat[k] = 1'b0;
			vsat[k] = 1'b0;
			acc = '0;
			foreach (class_wt[idx]) begin
				cnt[0] = 8'(idx / 64); cnt[1] = 8'(idx % 64);
				cnt[2] = cnt[0] + (cnt[1] << 1);
				acc += cnt[k] * class_wt[idx];
			end
			mean[k] = clip48(acc, msat[k]);
			acc = '0;
			foreach (class_wt[idx]) begin
				cnt[0] = 8'(idx / 64); cnt[1] = 8'(idx % 64);
				cnt[2] = cnt[0] + (cnt[1] << 1);
				tq = 128'(cnt[k]) << FRAC;
				d = (tq >= mean[k]) ? tq - mean[k] : mean[k] - tq;
				prod = d * d * class_wt[idx];
				if (prod[127:96] != 0) begin
					vsat[k] = 1'b1;
					acc += VAL_MAX;
				end else
					acc += prod >> 48;
			end
			vsum[k] = clip48(acc, vsat[k]);
		end
		rsat = msat[2] | vsat[2];
		if (mean[2] == 0)
			ratio = '0;
		else begin
			q = vsum[2] / mean[2];
			if (q >= (128'd1 << FRAC)) begin
				rsat = 1'b1;
				ratio = VAL_MAX;
			end else begin
				q = (128'(vsum[2]) << FRAC) / mean[2];
				ratio = q[VW-1:0];
			end
		end
		for (int k = 0; k < 7; k++) begin
			s.code = STAT_ORDER[k];
			if (k == 6) begin
				s.val = ratio;
				s.sat = rsat;
			end else if (k % 2 == 0) begin
				s.val = mean[k / 2];
				s.sat = msat[k / 2];
			end else begin
				s.val = vsum[k / 2];
				s.sat = msat[k / 2] | vsat[k / 2];
			end
			s.sat |= cell_clipped;
			s.fin = (k == 6);
			expected_stats.push_back(s);
		end
		class_wt.delete();
		cell_clipped = 1'b0;
	endtask

	always @(posedge clk) begin
		logic [26:0] sum;
		stat_t       e;
		int          idx;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				idx = het_count * 64 + hom_count;
				sum = (class_wt.exists(idx) ? class_wt[idx] : 27'd0) + weight;
				if (sum > CELL_MAX) begin
					sum = CELL_MAX;
					cell_clipped = 1'b1;
				end
				class_wt[idx] = sum[CELLW-1:0];
				if (last) begin
					predict_batch_stats();
					batches_done++;
				end
			end
			if (out_valid && out_ready) begin
				if (expected_stats.size() == 0) begin
					report_mismatch("unexpected stat_code", VW'(stat_code), '0);
				end else begin
					e = expected_stats.pop_front();
					stats_checked++;
					if (stat_code !== e.code)
						report_mismatch("stat_code", VW'(stat_code), VW'(e.code));
					if (value !== e.val) report_mismatch("value", value, e.val);
					if (saturated !== e.sat)
						report_mismatch("saturated", VW'(saturated), VW'(e.sat));
					if (last_result !== e.fin)
						report_mismatch("last_result", VW'(last_result), VW'(e.fin));
				end
			end
			pending = expected_stats.size();
		end
	end

endmodule

### dv/tb_load_class_weighted_moments_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_load_class_weighted_moments_core
// Sends batches of weighted load classes (directed extremes, cell overflow,
// empty and single-class batches, then random batches) with random idling on
// both sides; the checker predicts and compares every statistic.
// ----------------------------------------------------------------------------
module tb_load_class_weighted_moments_core;
	import lcwm_pkg::*;

	localparam int IDLE_LIMIT = 150000;
	localparam int RX_HOLD    = 500;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_ready;
	logic [CNTW-1:0] het_count = '0;
	logic [CNTW-1:0] hom_count = '0;
	logic [WGTW-1:0] weight = '0;
	logic            last = 1'b0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	logic [2:0]      stat_code;
	logic [VW-1:0]   value;
	logic            saturated;
	logic            last_result;
	logic            calm = 1'b0;
	int              fail_count, pending, batches_done, stats_checked;
	int              sent = 0;
	int              quiet_cycles = 0;
	int              rx_taken = 0, rx_hold_left = 0, rx_idle_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	load_class_weighted_moments_core uut (
		.clk, .arst_n, .in_valid, .in_ready, .het_count, .hom_count, .weight, .last,
		.out_valid, .out_ready, .stat_code, .value, .saturated, .last_result
	);

	lcwm_moments_checker chk (
		.clk, .arst_n, .in_valid, .in_ready, .het_count, .hom_count, .weight, .last,
		.out_valid, .out_ready, .stat_code, .value, .saturated, .last_result,
		.fail_count, .pending, .batches_done, .stats_checked
	);

	// result side: random stalls, one long hold-off to back the core up
	always @(posedge clk) begin
		if (out_valid && out_ready)
			rx_taken++;
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else if (out_valid && out_ready && rx_taken == 10) begin
			rx_hold_left = RX_HOLD;
			out_ready <= 1'b0;
		end else if (rx_idle_left > 0) begin
			rx_idle_left--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			rx_idle_left = $urandom_range(1, 6) - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
			$display("load_class_weighted_moments_core regression: fail");
			$finish;
		end
	end

	task automatic send_class(input logic [5:0] het, input logic [5:0] hom,
			input logic [WGTW-1:0] w, input logic fin);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		het_count <= het;
		hom_count <= hom;
		weight <= w;
		last <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	function automatic logic [WGTW-1:0] pick_weight();
		case ($urandom_range(0, 3))
			0: return WGTW'($urandom);
			1: return WGTW'($urandom_range(0, 255));
			2: return WGTW'($urandom_range(0, 1 << 24));
			default: return WGTW'($urandom_range(0, 1 << 20));
		endcase
	endfunction

	initial begin
		int len;
		int nbatch;
		logic [5:0] h, m;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// extremes and repeated max-weight class (cell overflow)
		send_class(6'd0, 6'd0, '0, 1'b0);
		send_class(6'd63, 6'd63, 25'h1FFFFFF, 1'b0);
		send_class(6'd63, 6'd0, 25'd1 << 24, 1'b0);
		send_class(6'd0, 6'd63, 25'd1, 1'b0);
		send_class(6'd63, 6'd63, 25'h1FFFFFF, 1'b0);
		send_class(6'd63, 6'd63, 25'h1FFFFFF, 1'b1);
		// zero-weight batch: every statistic is zero
		send_class(6'd5, 6'd7, '0, 1'b1);
		// single-class batches, and a two-class batch with alternating-bit weights
		send_class(6'd1, 6'd0, 25'd1, 1'b1);
		send_class(6'd42, 6'd21, 25'h0AAAAAA, 1'b0);
		send_class(6'd21, 6'd42, 25'h1555555, 1'b1);
		send_class(6'd0, 6'd0, 25'd1 << 24, 1'b1);

		nbatch = 0;
		while (sent < 460) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
			if (sent + len > 460) len = (460 - sent < 1) ? 1 : 460 - sent;
			if (nbatch == 5) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if (sent >= 400) calm <= 1'b1;
			h = 6'($urandom_range(0, 63));
			m = 6'($urandom_range(0, 63));
			for (int i = 0; i < len; i++) begin
				// revisit a recent class now and then so weights pile up
				if ($urandom_range(0, 3) != 0) begin
					h = 6'($urandom_range(0, 63));
					m = 6'($urandom_range(0, 63));
				end
				send_class(h, m, pick_weight(), i == len - 1);
			end
			nbatch++;
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d requests in %0d batches, %0d statistics checked",
			sent, batches_done, stats_checked);
		$display("incl. cell overflow, zero batch, long result hold-off, drained pause");
		if (fail_count == 0)
			$display("load_class_weighted_moments_core regression: pass");
		else
			$display("load_class_weighted_moments_core regression: fail");
		$finish;
	end

endmodule
